// File: hw/rtl/opfa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// opfa_pkg
// shared constants and types for the outlier filtered point averager
// ----------------------------------------------------------------------------
package opfa_pkg;

	localparam int MAX_POINTS = 256;
	localparam int ADDR_W     = $clog2(MAX_POINTS);
	localparam int CNT_W      = ADDR_W + 1;
	localparam int SUM_W      = 32 + ADDR_W;
	localparam int DIV_W      = 72;
	localparam int MIN_FILTER = 5;
	localparam int MIN_KEPT   = 3;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_FILTER_EN = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ZSCORE    = 1'd1;

	typedef logic signed [31:0]    coord_t;
	typedef logic signed [SUM_W-1:0] sum_t;
	typedef logic [CNT_W-1:0]      cnt_t;

	typedef enum logic [14:0] {
		S_LOAD = 15'h0001,
		S_MEAN = 15'h0002,
		S_P1RD = 15'h0004,
		S_P1DL = 15'h0008,
		S_P1SQ = 15'h0010,
		S_P1RT = 15'h0020,
		S_MSQ  = 15'h0040,
		S_DAVG = 15'h0080,
		S_VAR  = 15'h0100,
		S_SIG  = 15'h0200,
		S_CUT  = 15'h0400,
		S_P2RD = 15'h0800,
		S_P2CK = 15'h1000,
		S_FIN  = 15'h2000,
		S_OUT  = 15'h4000
	} state_t;

endpackage
`default_nettype wire

// File: hw/rtl/outlier_filtered_point_average.sv
`default_nettype none
// ----------------------------------------------------------------------------
// outlier_filtered_point_average
// stores a run of points, then gives its mean or its z-score filtered mean
// ----------------------------------------------------------------------------
// points load one per cycle into the point memory while the block is loading;
// a run of n points then goes through the means, the distance pass
// (one shared 2-bit-per-cycle square root), the statistics,
// the filter pass and the final means.
// results sit in an output register, so the next run loads while one waits.
// reset clears run state and sets filter on, zscore 2.0; memories hold junk.
module outlier_filtered_point_average (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [95:0]                    s_tdata,  // point_x, point_y, point_z
	input  wire logic                           s_tlast,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [111:0]                        m_tdata,  // avg_x, avg_y, avg_z, kept_count
	output logic [1:0]                          m_tuser,  // fell_back, overflowed
	input  wire logic                           cfg_we,
	input  wire logic [opfa_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [15:0]                    cfg_data
);
	import opfa_pkg::*;

	state_t state_q;
	logic   st_q;
	logic [1:0] ax_q;
	logic [1:0] sc_q;

	logic        filt_en_q;
	logic [15:0] zscore_q;

	cnt_t   cnt_q, idx_q, kcnt_q, kept_q;
	logic   ovf_q, fell_q;
	sum_t   sum_q [3];
	sum_t   fsum_q [3];
	coord_t mean_q [3];
	coord_t res_q [3];

	logic [95:0]  pt_mem [MAX_POINTS];
	logic [31:0]  dist_mem [MAX_POINTS];
	logic [95:0]  pt_rd_q;
	logic [31:0]  dist_rd_q;

	logic [32:0]  mag_q [3];
	logic [65:0]  prod_q;
	logic [63:0]  acc_q;
	logic [DIV_W-1:0] ssum_q;
	logic [SUM_W-1:0] dsum_q;
	logic [63:0]  msq_q, dsq_q;
	logic [31:0]  davg_q, sigma_q;
	logic [47:0]  cut_q;

	// shared divider
	logic             div_go, div_busy_q, div_rdy;
	logic [DIV_W-1:0] div_dvd, div_q;
	cnt_t             div_dvs, div_n_q;
	logic [CNT_W:0]   div_rem_q, div_sh;
	logic [6:0]       div_cnt_q;

	// shared square root
	logic        sq_go, sq_busy_q, sq_rdy;
	logic [63:0] sq_arg, sq_in_q;
	logic [33:0] sq_rem_q, sq_sh, sq_trial;
	logic [31:0] sq_root_q;
	logic [4:0]  sq_cnt_q;

	logic        load_acc, out_free, p1_wr, keep;
	logic [31:0] dev;
	logic [63:0] var_w;

	function automatic logic [DIV_W-1:0] rnd_dvd(sum_t s, cnt_t n);
		logic [SUM_W-1:0] m;
		m = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
		return DIV_W'(m) + DIV_W'(n >> 1);
	endfunction

	function automatic coord_t rnd_res(logic [DIV_W-1:0] q, logic neg);
		logic [31:0] v;
		v = q[31:0];
		return neg ? coord_t'(-v) : coord_t'(v);
	endfunction

	assign s_tready = (state_q == S_LOAD);
	assign load_acc = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;
	assign div_rdy  = st_q && !div_busy_q;
	assign sq_rdy   = st_q && !sq_busy_q;
	assign p1_wr    = (state_q == S_P1RT) && sq_rdy;
	assign var_w    = (msq_q > dsq_q) ? (msq_q - dsq_q) : 64'd0;
	assign dev      = (dist_rd_q > davg_q) ? (dist_rd_q - davg_q) : (davg_q - dist_rd_q);
	assign keep     = 48'({dev, 8'h00}) <= cut_q;

	always_comb begin
		div_go  = 1'b0;
		div_dvd = '0;
		div_dvs = cnt_q;
		sq_go   = 1'b0;
		sq_arg  = acc_q;
		case (state_q)
			S_MEAN: begin
				div_go  = !st_q;
				div_dvd = rnd_dvd(sum_q[ax_q], cnt_q);
			end
			S_MSQ: begin
				div_go  = !st_q;
				div_dvd = ssum_q;
			end
			S_DAVG: begin
				div_go  = !st_q;
				div_dvd = DIV_W'(dsum_q) + DIV_W'(cnt_q >> 1);
			end
			S_FIN: begin
				div_go  = !st_q && (kcnt_q >= CNT_W'(MIN_KEPT));
				div_dvs = kcnt_q;
				div_dvd = rnd_dvd(fsum_q[ax_q], kcnt_q);
			end
			S_P1RT: begin
				sq_go = !st_q;
			end
			S_SIG: begin
				sq_go  = !st_q;
				sq_arg = var_w;
			end
			default: begin
			end
		endcase
	end

	// restoring divider, one quotient bit a cycle
	assign div_sh = {div_rem_q[CNT_W-1:0], div_q[DIV_W-1]};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_cnt_q  <= '0;
		end else if (div_go) begin
			div_busy_q <= 1'b1;
			div_cnt_q  <= 7'(DIV_W - 1);
		end else if (div_busy_q) begin
			div_cnt_q <= div_cnt_q - 7'd1;
			if (div_cnt_q == 7'd0) div_busy_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (div_go) begin
			div_q     <= div_dvd;
			div_rem_q <= '0;
			div_n_q   <= div_dvs;
		end else if (div_busy_q) begin
			if (div_sh >= {1'b0, div_n_q}) begin
				div_rem_q <= div_sh - {1'b0, div_n_q};
				div_q     <= {div_q[DIV_W-2:0], 1'b1};
			end else begin
				div_rem_q <= div_sh;
				div_q     <= {div_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	// digit-by-digit square root, two radicand bits a cycle
	assign sq_sh    = {sq_rem_q[31:0], sq_in_q[63:62]};
	assign sq_trial = {sq_root_q, 2'b01};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_busy_q <= 1'b0;
			sq_cnt_q  <= '0;
		end else if (sq_go) begin
			sq_busy_q <= 1'b1;
			sq_cnt_q  <= 5'd31;
		end else if (sq_busy_q) begin
			sq_cnt_q <= sq_cnt_q - 5'd1;
			if (sq_cnt_q == 5'd0) sq_busy_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (sq_go) begin
			sq_in_q   <= sq_arg;
			sq_rem_q  <= '0;
			sq_root_q <= '0;
		end else if (sq_busy_q) begin
			sq_in_q <= {sq_in_q[61:0], 2'b00};
			if (sq_sh >= sq_trial) begin
				sq_rem_q  <= sq_sh - sq_trial;
				sq_root_q <= {sq_root_q[30:0], 1'b1};
			end else begin
				sq_rem_q  <= sq_sh;
				sq_root_q <= {sq_root_q[30:0], 1'b0};
			end
		end
	end

	// memories
	always_ff @(posedge clk) begin
		if (load_acc && (cnt_q != CNT_W'(MAX_POINTS))) pt_mem[cnt_q[ADDR_W-1:0]] <= s_tdata;
		pt_rd_q <= pt_mem[idx_q[ADDR_W-1:0]];
	end
	always_ff @(posedge clk) begin
		if (p1_wr) dist_mem[idx_q[ADDR_W-1:0]] <= sq_root_q;
		dist_rd_q <= dist_mem[idx_q[ADDR_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_en_q <= 1'b1;
			zscore_q  <= 16'd512;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_FILTER_EN: filt_en_q <= cfg_data[0];
				CFG_ZSCORE:    zscore_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_LOAD;
			st_q     <= 1'b0;
			ax_q     <= '0;
			sc_q     <= '0;
			cnt_q    <= '0;
			idx_q    <= '0;
			ovf_q    <= 1'b0;
			m_tvalid <= 1'b0;
			for (int a = 0; a < 3; a++) sum_q[a] <= '0;
		end else begin
			// a result taken while the next one is ready is refilled in S_OUT
			if (m_tvalid && m_tready && (state_q != S_OUT)) m_tvalid <= 1'b0;
			case (state_q)
				S_LOAD: begin
					if (load_acc) begin
						if (cnt_q != CNT_W'(MAX_POINTS)) begin
							cnt_q <= cnt_q + CNT_W'(1);
							for (int a = 0; a < 3; a++)
								sum_q[a] <= sum_q[a] + SUM_W'(signed'(s_tdata[32*a +: 32]));
						end else begin
							ovf_q <= 1'b1;
						end
						if (s_tlast) begin
							state_q <= S_MEAN;
							ax_q    <= '0;
						end
					end
				end
				S_MEAN: begin
					if (!st_q) st_q <= 1'b1;
					else if (div_rdy) begin
						st_q <= 1'b0;
						mean_q[ax_q] <= (cnt_q == '0) ? '0 : rnd_res(div_q, sum_q[ax_q][SUM_W-1]);
						res_q[ax_q]  <= (cnt_q == '0) ? '0 : rnd_res(div_q, sum_q[ax_q][SUM_W-1]);
						ax_q <= ax_q + 2'd1;
						if (ax_q == 2'd2) begin
							kept_q <= cnt_q;
							fell_q <= filt_en_q;
							idx_q  <= '0;
							ssum_q <= '0;
							dsum_q <= '0;
							if (filt_en_q && (cnt_q >= CNT_W'(MIN_FILTER))) begin
								fell_q  <= 1'b0;
								state_q <= S_P1RD;
							end else begin
								state_q <= S_OUT;
							end
						end
					end
				end
				S_P1RD: state_q <= S_P1DL;
				S_P1DL: begin
					for (int a = 0; a < 3; a++) begin
						logic signed [32:0] d;
						d = 33'(signed'(pt_rd_q[32*a +: 32])) - 33'(mean_q[a]);
						mag_q[a] <= d[32] ? 33'(-d) : 33'(d);
					end
					acc_q   <= '0;
					sc_q    <= '0;
					state_q <= S_P1SQ;
				end
				S_P1SQ: begin
					// multiply one axis while the previous square is summed
					if (sc_q != 2'd3) prod_q <= mag_q[sc_q] * mag_q[sc_q];
					if (sc_q != 2'd0) acc_q <= acc_q + {2'b00, prod_q[63:2]};
					sc_q <= sc_q + 2'd1;
					if (sc_q == 2'd3) state_q <= S_P1RT;
				end
				S_P1RT: begin
					if (!st_q) st_q <= 1'b1;
					else if (sq_rdy) begin
						st_q   <= 1'b0;
						dsum_q <= dsum_q + SUM_W'(sq_root_q);
						ssum_q <= ssum_q + DIV_W'(acc_q);
						idx_q  <= idx_q + CNT_W'(1);
						state_q <= (idx_q == cnt_q - CNT_W'(1)) ? S_MSQ : S_P1RD;
					end
				end
				S_MSQ: begin
					if (!st_q) st_q <= 1'b1;
					else if (div_rdy) begin
						st_q    <= 1'b0;
						msq_q   <= div_q[63:0];
						state_q <= S_DAVG;
					end
				end
				S_DAVG: begin
					if (!st_q) st_q <= 1'b1;
					else if (div_rdy) begin
						st_q    <= 1'b0;
						davg_q  <= div_q[31:0];
						state_q <= S_VAR;
					end
				end
				S_VAR: begin
					dsq_q   <= davg_q * davg_q;
					state_q <= S_SIG;
				end
				S_SIG: begin
					if (!st_q) st_q <= 1'b1;
					else if (sq_rdy) begin
						st_q    <= 1'b0;
						sigma_q <= sq_root_q;
						state_q <= S_CUT;
					end
				end
				S_CUT: begin
					cut_q   <= zscore_q * sigma_q;
					idx_q   <= '0;
					kcnt_q  <= '0;
					for (int a = 0; a < 3; a++) fsum_q[a] <= '0;
					state_q <= S_P2RD;
				end
				S_P2RD: state_q <= S_P2CK;
				S_P2CK: begin
					if (keep) begin
						kcnt_q <= kcnt_q + CNT_W'(1);
						for (int a = 0; a < 3; a++)
							fsum_q[a] <= fsum_q[a] + SUM_W'(signed'(pt_rd_q[32*a +: 32]));
					end
					idx_q <= idx_q + CNT_W'(1);
					ax_q  <= '0;
					state_q <= (idx_q == cnt_q - CNT_W'(1)) ? S_FIN : S_P2RD;
				end
				S_FIN: begin
					if (kcnt_q < CNT_W'(MIN_KEPT)) begin
						// too few kept, plain mean stays in res_q
						fell_q  <= 1'b1;
						state_q <= S_OUT;
					end else if (!st_q) st_q <= 1'b1;
					else if (div_rdy) begin
						st_q <= 1'b0;
						res_q[ax_q] <= rnd_res(div_q, fsum_q[ax_q][SUM_W-1]);
						ax_q <= ax_q + 2'd1;
						if (ax_q == 2'd2) begin
							kept_q  <= kcnt_q;
							state_q <= S_OUT;
						end
					end
				end
				S_OUT: begin
					if (out_free) begin
						m_tvalid <= 1'b1;
						m_tdata  <= {7'd0, kept_q, res_q[2], res_q[1], res_q[0]};
						m_tuser  <= {ovf_q, fell_q};
						cnt_q    <= '0;
						ovf_q    <= 1'b0;
						for (int a = 0; a < 3; a++) sum_q[a] <= '0;
						state_q  <= S_LOAD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(div_busy_q && sq_busy_q)) else $error("divider and sqrt busy together");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_POINTS)) else $error("stored count past capacity");

	a_pass_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_P1RD || state_q == S_P2RD) |-> (idx_q < cnt_q))
		else $error("pass index past stored points");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && out_free) |=> (m_tvalid && state_q == S_LOAD))
		else $error("result not presented");

endmodule
`default_nettype wire

// File: dv/opfa_checker.sv
// ----------------------------------------------------------------------------
// opfa_checker
// watches the point and average streams, predicts each run's averaged point
// and compares it field by field with what the averager gives
// ----------------------------------------------------------------------------
module opfa_checker (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	input  wire logic         s_tready,
	input  wire logic [95:0]  s_tdata,
	input  wire logic         s_tlast,
	input  wire logic         m_tvalid,
	input  wire logic         m_tready,
	input  wire logic [111:0] m_tdata,
	input  wire logic [1:0]   m_tuser,
	input  wire logic         cfg_we,
	input  wire logic [opfa_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [15:0]  cfg_data,
	output int                fail_count,
	output int                pending,
	output int                results,
	output int                fallbacks
);
	import opfa_pkg::*;

	typedef struct packed {
		coord_t     x;
		coord_t     y;
		coord_t     z;
		logic [8:0] kept;
		logic       fell;
		logic       ovf;
	} avg_t;

	avg_t        expected_avgs[$];
	coord_t      run_pts[MAX_POINTS][3];
	int unsigned run_len;
	longint      run_sums[3];
	bit          run_ovf;
	bit          filter_on;
	bit [15:0]   zscore;

	initial begin
		fail_count = 0;
		pending    = 0;
		results    = 0;
		fallbacks  = 0;
		run_len    = 0;
		run_sums   = '{0, 0, 0};
		run_ovf    = 0;
		filter_on  = 1;
		zscore     = 16'd512;
	end

	function automatic bit [63:0] floor_sqrt(bit [63:0] v);
		bit [63:0] r, b;
		r = 0;
		b = 64'h1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// ties round away from zero
	function automatic longint div_round(longint s, int unsigned n);
		bit [63:0] m, q;
		m = (s < 0) ? -s : s;
		q = (m + n / 2) / n;
		return (s < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic bit [63:0] dist_sq(int unsigned i, longint mean[3]);
		bit [63:0] acc, m;
		longint d;
		acc = 0;
		for (int a = 0; a < 3; a++) begin
			d = longint'(run_pts[i][a]) - mean[a];
			m = (d < 0) ? -d : d;
			acc += (m * m) >> 2;
		end
		return acc;
	endfunction

	function automatic avg_t run_average();
		avg_t       r;
		longint     mean[3], fsum[3];
		bit [127:0] sq_total;
		bit [63:0]  s, dsum, msq, davg, dsq, vr, cut, d, dev;
		int unsigned n, cnt;
		n = run_len;
		for (int a = 0; a < 3; a++) mean[a] = (n != 0) ? div_round(run_sums[a], n) : 0;
		r.x = mean[0];
		r.y = mean[1];
		r.z = mean[2];
		r.kept = n;
		r.fell = 0;
		r.ovf = run_ovf;
		if (filter_on) begin
			if (n < MIN_FILTER) begin
				r.fell = 1;
			end else begin
				sq_total = 0;
				dsum = 0;
				for (int unsigned i = 0; i < n; i++) begin
					s = dist_sq(i, mean);
					sq_total += s;
					dsum += floor_sqrt(s);
				end
				msq = sq_total / n;
				davg = (dsum + n / 2) / n;
				dsq = davg * davg;
				vr = (msq > dsq) ? msq - dsq : 0;
				cut = zscore * floor_sqrt(vr);
				fsum = '{0, 0, 0};
				cnt = 0;
				for (int unsigned i = 0; i < n; i++) begin
					d = floor_sqrt(dist_sq(i, mean));
					dev = (d > davg) ? d - davg : davg - d;
					if ((dev << 8) > cut) continue;
					for (int a = 0; a < 3; a++) fsum[a] += run_pts[i][a];
					cnt++;
				end
				if (cnt < MIN_KEPT) begin
					r.fell = 1;
				end else begin
					r.x = div_round(fsum[0], cnt);
					r.y = div_round(fsum[1], cnt);
					r.z = div_round(fsum[2], cnt);
					r.kept = cnt;
				end
			end
		end
		return r;
	endfunction

	task automatic check_field(string name, longint exp_v, longint got_v);
		if (exp_v != got_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		avg_t e;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_FILTER_EN: filter_on = cfg_data[0];
					CFG_ZSCORE:    zscore = cfg_data;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (expected_avgs.size() == 0) begin
					$error("average arrived with no run closed");
					fail_count++;
				end else begin
					e = expected_avgs.pop_front();
					check_field("avg_x", e.x, coord_t'(m_tdata[31:0]));
					check_field("avg_y", e.y, coord_t'(m_tdata[63:32]));
					check_field("avg_z", e.z, coord_t'(m_tdata[95:64]));
					check_field("kept_count", e.kept, m_tdata[104:96]);
					check_field("fell_back", e.fell, m_tuser[0]);
					check_field("overflowed", e.ovf, m_tuser[1]);
					check_field("pad", 0, m_tdata[111:105]);
					results++;
					if (e.fell) fallbacks++;
				end
			end
			if (s_tvalid && s_tready) begin
				if (run_len < MAX_POINTS) begin
					for (int a = 0; a < 3; a++) begin
						run_pts[run_len][a] = s_tdata[32*a +: 32];
						run_sums[a] += longint'(coord_t'(s_tdata[32*a +: 32]));
					end
					run_len++;
				end else begin
					run_ovf = 1;
				end
				if (s_tlast) begin
					expected_avgs.push_back(run_average());
					run_len = 0;
					run_sums = '{0, 0, 0};
					run_ovf = 0;
				end
			end
			pending = expected_avgs.size();
		end
	end

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// point run stimulus for the outlier filtered point averager
// ----------------------------------------------------------------------------
// directed runs hit the coordinate extremes, short and uniform runs, then
// random clustered runs with outliers go through under three idle patterns
// and several filter settings, including capacity overflow
module testbench;
	import opfa_pkg::*;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_tvalid = 0;
	logic         s_tready;
	logic [95:0]  s_tdata = '0;  // point_x, point_y, point_z
	logic         s_tlast = 0;
	logic         m_tvalid;
	logic         m_tready = 0;
	logic [111:0] m_tdata;       // avg_x, avg_y, avg_z, kept_count
	logic [1:0]   m_tuser;       // fell_back, overflowed
	logic         cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_idx = CFG_FILTER_EN;
	logic [15:0]  cfg_data = '0;

	int fail_count, pending, results, fallbacks;
	int snd_idle = 0, rcv_idle = 0;
	int hold_req = 0, hold_seen = 0, hold_left = 0;
	int items_sent = 0, runs_sent = 0;

	always #5 clk = ~clk;

	outlier_filtered_point_average dut (.*);

	opfa_checker checker_i (.*);

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= 3000;
			m_tready <= 0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 0;
		end else begin
			m_tready <= ($urandom_range(99) >= rcv_idle);
		end
	end

	task automatic send_point(coord_t x, coord_t y, coord_t z, bit last);
		bit rdy;
		while ($urandom_range(99) < snd_idle) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {z, y, x};
		s_tlast <= last;
		do begin
			@(negedge clk);
			rdy = s_tready;
			@(posedge clk);
		end while (!rdy);
		items_sent++;
		if (last) runs_sent++;
	endtask

	task automatic go_quiet();
		s_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	function automatic coord_t jitter(coord_t c, int spread);
		return c + coord_t'($urandom_range(0, 2 * spread)) - coord_t'(spread);
	endfunction

	// kind 0: tight cluster with a few far points, kind 1: full range
	task automatic send_run(int len, int kind);
		coord_t cx, cy, cz;
		int spread;
		cx = coord_t'($urandom) >>> $urandom_range(0, 20);
		cy = coord_t'($urandom) >>> $urandom_range(0, 20);
		cz = coord_t'($urandom) >>> $urandom_range(0, 20);
		spread = 1 << $urandom_range(0, 20);
		for (int i = 0; i < len; i++) begin
			if (kind == 1)
				send_point($urandom, $urandom, $urandom, i == len - 1);
			else if ($urandom_range(99) < 15)
				send_point(jitter(cx, spread * 64), jitter(cy, spread * 32),
					jitter(cz, spread), i == len - 1);
			else
				send_point(jitter(cx, spread), jitter(cy, spread), jitter(cz, spread),
					i == len - 1);
		end
	endtask

	task automatic random_phase(int budget);
		int start;
		start = items_sent;
		while (items_sent - start < budget) begin
			if ($urandom_range(99) < 12)
				send_run($urandom_range(1, 4), $urandom_range(0, 1));
			else
				send_run($urandom_range(5, 16), ($urandom_range(99) < 15));
		end
	endtask

	initial begin
		#30_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: single extreme point, two points at extremes
		send_point(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1);
		send_point(32'sh80000000, 32'sh80000000, 32'sh80000000, 0);
		send_point(32'sh80000000, 32'sh7FFFFFFF, 32'sh00000001, 1);
		// five points, one far outlier
		for (int i = 0; i < 4; i++) send_point(32'sh10000 + i, -32'sh20000, 32'sh0, 0);
		send_point(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 1);
		// four points: too few for the filter
		for (int i = 0; i < 4; i++) send_point(i * 32'sh1000, 0, -i, i == 3);
		// identical points, zero variance
		for (int i = 0; i < 5; i++) send_point(32'sh123456, -32'sh654321, 32'sh1, i == 4);
		// alternating extremes
		for (int i = 0; i < 6; i++)
			send_point(i[0] ? 32'sh7FFFFFFF : 32'sh80000000,
				i[1] ? 32'sh7FFFFFFF : 32'sh80000000, 32'sh0, i == 5);
		go_quiet();

		// long receiver hold-off while runs keep coming
		snd_idle = 8;
		rcv_idle = 88;
		hold_req++;
		for (int r = 0; r < 4; r++) send_run(6, 0);
		random_phase(600);
		go_quiet();

		write_reg(CFG_ZSCORE, 16'd0);
		random_phase(80);
		go_quiet();
		write_reg(CFG_ZSCORE, 16'hFFFF);
		write_reg(CFG_FILTER_EN, 16'hFFFE);
		snd_idle = 88;
		rcv_idle = 8;
		random_phase(500);
		go_quiet();

		write_reg(CFG_FILTER_EN, 16'd1);
		write_reg(CFG_ZSCORE, 16'd200);
		snd_idle = 0;
		rcv_idle = 0;
		random_phase(250);
		// exactly full, then overflow with the closing point ignored
		send_run(MAX_POINTS, 0);
		go_quiet();
		write_reg(CFG_ZSCORE, 16'd384);
		send_run(MAX_POINTS + 4, 0);
		random_phase(150);
		go_quiet();

		$display("sent %0d points in %0d runs, checked %0d averages (%0d fell back)",
			items_sent, runs_sent, results, fallbacks);
		if (fail_count == 0 && pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
